@@ sv/convex_hull_monotone_chain_unit_assert.svh @@
// assertion macros for the convex hull unit
// each takes a label and a property expression; the clock is clk, reset arst_n
`ifndef CONVEX_HULL_MONOTONE_CHAIN_UNIT_ASSERT_SVH
`define CONVEX_HULL_MONOTONE_CHAIN_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CHM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("chm assertion failed");
`define CHM_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("chm forbidden condition");
`else
`define CHM_ASSERT(lbl, prop)
`define CHM_ASSERT_NEVER(lbl, cond)
`endif
`endif

@@ sv/chm_pkg.sv @@
`timescale 1ns / 1ps
package chm_pkg;

	// stream data is padded to whole bytes
	localparam int BYTE_BITS = 8;

	// direction of the chain being built
	typedef enum logic {
		DIR_DOWN = 1'b0,
		DIR_UP   = 1'b1
	} chm_dir_t;

endpackage

@@ sv/convex_hull_monotone_chain_unit.sv @@
`timescale 1ns / 1ps
// channel   dir  tdata (low bit up)          tlast       tuser
// s_axis    in   point_x, point_y            set_end     -
// m_axis    out  hull_x, hull_y              hull_last   overflowed
//
// a point that is not the last of its set is stored (dropped once full); s_axis stays ready
// on the last point the store is insertion sorted
// each chain point is fetched, then turn tested, popping and reloading from the stack,
// all through one shared multiplier and one store read port
// each hull vertex is held on m_axis until taken; s_axis is not ready meanwhile
// reset clears the point count, the drop flag and the sequencer; the stores need no clearing
`include "convex_hull_monotone_chain_unit_assert.svh"
module convex_hull_monotone_chain_unit #(
	parameter int MAX_POINTS = 32,
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// point_x, point_y
	input  logic [((2*COORD_BITS+chm_pkg::BYTE_BITS-1)/chm_pkg::BYTE_BITS)
		*chm_pkg::BYTE_BITS-1:0] s_axis_tdata,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// hull_x, hull_y
	output logic [((2*COORD_BITS+chm_pkg::BYTE_BITS-1)/chm_pkg::BYTE_BITS)
		*chm_pkg::BYTE_BITS-1:0] m_axis_tdata,
	output logic m_axis_tlast,
	// overflowed
	output logic m_axis_tuser
);

	import chm_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int PW = 2 * COORD_BITS;
	localparam int DW = ((PW + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SW = $clog2(2 * MAX_POINTS);
	localparam int MW = 2 * COORD_BITS + 2;

	typedef enum logic [4:0] {
		S_IDLE, S_SORT_I, S_SORT_T, S_SORT_C, S_SORT_W,
		S_CH_RD, S_CH_LD, S_DIFF, S_MUL1, S_MUL2, S_TURN,
		S_POP, S_POP_S, S_POP_P, S_PUSH,
		S_EM_RD, S_EM_ST, S_EM_OUT, S_EM_WAIT
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q, i_q, k_q, top_q, up_q, e_q;
	logic [IW-1:0] j_q;
	logic drop_q;
	chm_dir_t dir_q;
	logic signed [CB-1:0] tx_q, ty_q, ax_q, ay_q, bx_q, by_q, px_q, py_q;
	logic signed [CB:0] dax_q, day_q, dbx_q, dby_q;
	logic signed [MW-1:0] m1_q, m2_q;
	logic [CB-1:0] ox_q, oy_q;
	logic olast_q, ovalid_q;

	// store and stack ports
	logic st_we, sk_we;
	logic [IW-1:0] st_waddr, st_raddr, sk_wdata, sk_rdata, chain_i;
	logic [PW-1:0] st_wdata, st_rdata;
	logic [SW-1:0] sk_waddr, sk_raddr, base;
	logic signed [CB-1:0] rd_x, rd_y;
	logic [CW-1:0] desc_k, top_m3, em_limit;
	logic pt_less, accept;

	// shared multiplier
	logic signed [CB:0] mul_a, mul_b;
	logic signed [MW-1:0] mul_p;

	assign rd_x = st_rdata[CB-1:0];
	assign rd_y = st_rdata[PW-1:CB];
	assign pt_less = (tx_q < rd_x) || ((tx_q == rd_x) && (ty_q < rd_y));
	assign desc_k = cnt_q - CW'(1) - k_q;
	assign chain_i = (dir_q == DIR_UP) ? k_q[IW-1:0] : desc_k[IW-1:0];
	assign base = (dir_q == DIR_UP) ? '0 : SW'(MAX_POINTS);
	assign top_m3 = top_q - CW'(3);
	assign em_limit = (dir_q == DIR_UP) ? (up_q - CW'(1)) : top_q;
	assign accept = s_axis_tvalid && (state_q == S_IDLE);

	assign mul_a = (state_q == S_MUL1) ? dax_q : day_q;
	assign mul_b = (state_q == S_MUL1) ? dby_q : dbx_q;
	assign mul_p = MW'(mul_a) * MW'(mul_b);

	// store port control
	always_comb begin
		st_we = 1'b0;
		st_waddr = j_q;
		st_wdata = {ty_q, tx_q};
		st_raddr = chain_i;
		case (state_q)
			S_IDLE: begin
				st_we = accept && (cnt_q < CW'(MAX_POINTS));
				st_waddr = cnt_q[IW-1:0];
				st_wdata = {s_axis_tdata[PW-1:CB], s_axis_tdata[CB-1:0]};
			end
			S_SORT_I: st_raddr = i_q[IW-1:0];
			S_SORT_T: st_raddr = i_q[IW-1:0] - IW'(1);
			S_SORT_C: begin
				st_we = pt_less;
				st_wdata = st_rdata;
				st_raddr = j_q - IW'(2);
			end
			S_SORT_W: st_we = 1'b1;
			S_POP_S: st_raddr = sk_rdata;
			S_EM_ST: st_raddr = sk_rdata;
			default: st_raddr = chain_i;
		endcase
	end

	// stack port control
	always_comb begin
		sk_we = (state_q == S_PUSH) && (top_q < CW'(MAX_POINTS));
		sk_waddr = base + SW'(top_q);
		sk_wdata = chain_i;
		sk_raddr = (state_q == S_POP) ? (base + SW'(top_m3)) : (base + SW'(e_q));
	end

	chm_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	chm_ram #(.WIDTH(IW), .DEPTH(2 * MAX_POINTS)) u_stack (
		.clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
		.raddr(sk_raddr), .rdata(sk_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			drop_q <= 1'b0;
			ovalid_q <= 1'b0;
			top_q <= '0;
			dir_q <= DIR_UP;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cnt_q < CW'(MAX_POINTS)) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							i_q <= CW'(1);
							state_q <= S_SORT_I;
						end
					end
				end
				// insertion sort by x, then y
				S_SORT_I: begin
					if (i_q >= cnt_q) begin
						dir_q <= DIR_UP;
						k_q <= '0;
						top_q <= '0;
						state_q <= S_CH_RD;
					end else begin
						state_q <= S_SORT_T;
					end
				end
				S_SORT_T: begin
					tx_q <= rd_x;
					ty_q <= rd_y;
					j_q <= i_q[IW-1:0];
					state_q <= S_SORT_C;
				end
				S_SORT_C: begin
					if (pt_less) begin
						j_q <= j_q - IW'(1);
						if (j_q == IW'(1)) begin
							state_q <= S_SORT_W;
						end
					end else begin
						state_q <= S_SORT_W;
					end
				end
				S_SORT_W: begin
					i_q <= i_q + CW'(1);
					state_q <= S_SORT_I;
				end
				// chain build: fetch next point
				S_CH_RD: begin
					if (k_q == cnt_q) begin
						if (dir_q == DIR_UP) begin
							up_q <= top_q;
						end
						e_q <= '0;
						state_q <= S_EM_RD;
					end else begin
						state_q <= S_CH_LD;
					end
				end
				S_CH_LD: begin
					px_q <= rd_x;
					py_q <= rd_y;
					state_q <= (top_q > CW'(1)) ? S_DIFF : S_PUSH;
				end
				// turn test on (a, b, p)
				S_DIFF: begin
					dax_q <= (CB+1)'(bx_q) - (CB+1)'(ax_q);
					day_q <= (CB+1)'(by_q) - (CB+1)'(ay_q);
					dbx_q <= (CB+1)'(px_q) - (CB+1)'(ax_q);
					dby_q <= (CB+1)'(py_q) - (CB+1)'(ay_q);
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					m1_q <= mul_p;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					m2_q <= mul_p;
					state_q <= S_TURN;
				end
				S_TURN: state_q <= (m1_q >= m2_q) ? S_POP : S_PUSH;
				// pop: b takes a, a reloads from the stack if it held more than two
				S_POP: begin
					top_q <= top_q - CW'(1);
					bx_q <= ax_q;
					by_q <= ay_q;
					state_q <= (top_q > CW'(2)) ? S_POP_S : S_PUSH;
				end
				S_POP_S: state_q <= S_POP_P;
				S_POP_P: begin
					ax_q <= rd_x;
					ay_q <= rd_y;
					state_q <= S_DIFF;
				end
				S_PUSH: begin
					if (top_q < CW'(MAX_POINTS)) begin
						top_q <= top_q + CW'(1);
						ax_q <= bx_q;
						ay_q <= by_q;
						bx_q <= px_q;
						by_q <= py_q;
					end
					k_q <= k_q + CW'(1);
					state_q <= S_CH_RD;
				end
				// emit chain vertices
				S_EM_RD: begin
					if (e_q == em_limit) begin
						if (dir_q == DIR_UP) begin
							dir_q <= DIR_DOWN;
							k_q <= '0;
							top_q <= '0;
							state_q <= S_CH_RD;
						end else begin
							cnt_q <= '0;
							drop_q <= 1'b0;
							top_q <= '0;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_EM_ST;
					end
				end
				S_EM_ST: state_q <= S_EM_OUT;
				S_EM_OUT: begin
					ox_q <= st_rdata[CB-1:0];
					oy_q <= st_rdata[PW-1:CB];
					olast_q <= (dir_q == DIR_DOWN) && (e_q == top_q - CW'(1));
					ovalid_q <= 1'b1;
					state_q <= S_EM_WAIT;
				end
				S_EM_WAIT: begin
					if (m_axis_tready) begin
						ovalid_q <= 1'b0;
						e_q <= e_q + CW'(1);
						state_q <= S_EM_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = DW'({oy_q, ox_q});
	assign m_axis_tlast = olast_q;
	assign m_axis_tuser = drop_q;

	// checks
	`CHM_ASSERT_NEVER(a_no_out_when_idle, s_axis_tready && m_axis_tvalid)
	`CHM_ASSERT(a_cnt_bound, cnt_q <= CW'(MAX_POINTS))
	`CHM_ASSERT(a_top_bound, top_q <= CW'(MAX_POINTS))
	`CHM_ASSERT(a_out_in_wait, m_axis_tvalid |-> (state_q == S_EM_WAIT))

endmodule

@@ sv/chm_ram.sv @@
`timescale 1ns / 1ps
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ tb/tb_convex_hull_monotone_chain_unit.sv @@
`timescale 1ns / 1ps
module tb_convex_hull_monotone_chain_unit;

	localparam int MAX_PTS = 32;
	localparam int CB = 16;
	localparam int DW = ((2*CB+chm_pkg::BYTE_BITS-1)/chm_pkg::BYTE_BITS)*chm_pkg::BYTE_BITS;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic signed [15:0] y;
		logic signed [15:0] x;
	} pt_t;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic last;
		logic ovf;
	} vertex_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [DW-1:0] s_axis_tdata;	// point_x, point_y
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [DW-1:0] m_axis_tdata;	// hull_x, hull_y
	logic m_axis_tlast;
	logic m_axis_tuser;	// overflowed

	convex_hull_monotone_chain_unit DUT (.*);

	// predictor state
	pt_t pts [MAX_PTS];
	int n_pts;
	logic dropped;
	vertex_t hull_q[$];

	int errors;
	int cycles = 0;
	int send_idle_pct;
	int recv_stall_pct;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic pt_less(pt_t a, pt_t b);
		if (a.x != b.x) return a.x < b.x;
		return a.y < b.y;
	endfunction

	// sign of (p-o) x (q-o) not clockwise
	function automatic logic not_cw(pt_t o, pt_t p, pt_t q);
		longint ax, ay, bx, by;
		ax = longint'(p.x) - o.x;
		ay = longint'(p.y) - o.y;
		bx = longint'(q.x) - o.x;
		by = longint'(q.y) - o.y;
		return (ax*by - ay*bx) >= 0;
	endfunction

	function automatic void push_vertex(pt_t p, logic ovf);
		vertex_t v;
		v.x = p.x;
		v.y = p.y;
		v.last = 0;
		v.ovf = ovf;
		hull_q = {hull_q, v};
	endfunction

	// accumulate a point and compute the hull on the set end
	function automatic void predict_hull(pt_t p, logic is_end);
		pt_t tmp;
		int chain [MAX_PTS];
		int ctop;
		int j, k, i, start;
		if (n_pts < MAX_PTS) begin
			pts[n_pts] = p;
			n_pts++;
		end else
			dropped = 1;
		if (!is_end) return;
		for (i = 1; i < n_pts; i++) begin
			tmp = pts[i];
			j = i;
			while (j > 0 && pt_less(tmp, pts[j-1])) begin
				pts[j] = pts[j-1];
				j--;
			end
			pts[j] = tmp;
		end
		start = hull_q.size();
		// upper chain ascending, then lower chain descending
		for (int pass = 0; pass < 2; pass++) begin
			ctop = 0;
			for (k = 0; k < n_pts; k++) begin
				i = pass == 0 ? k : n_pts - 1 - k;
				while (ctop > 1 && not_cw(pts[chain[ctop-2]],
						pts[chain[ctop-1]], pts[i]))
					ctop--;
				if (ctop < MAX_PTS) begin
					chain[ctop] = i;
					ctop++;
				end
			end
			for (k = 0; k < ctop - (pass == 0 ? 1 : 0); k++)
				if (hull_q.size() - start < MAX_PTS + 1)
					push_vertex(pts[chain[k]], dropped);
		end
		if (hull_q.size() > start) hull_q[$].last = 1;
		n_pts = 0;
		dropped = 0;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// check each output transfer against the oldest expected vertex
	always @(posedge clk) begin
		vertex_t v;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (hull_q.size() == 0)
				report_mismatch("unexpected vertex", 1, 0);
			else begin
				v = hull_q.pop_front();
				if ($signed(m_axis_tdata[15:0]) != v.x)
					report_mismatch("hull_x", $signed(m_axis_tdata[15:0]), v.x);
				if ($signed(m_axis_tdata[31:16]) != v.y)
					report_mismatch("hull_y", $signed(m_axis_tdata[31:16]), v.y);
				if (m_axis_tlast !== v.last)
					report_mismatch("hull_last", m_axis_tlast, v.last);
				if (m_axis_tuser !== v.ovf)
					report_mismatch("overflowed", m_axis_tuser, v.ovf);
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic is_end);
		pt_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		p.x = x;
		p.y = y;
		s_axis_tvalid <= 1;
		s_axis_tdata <= DW'(p);
		s_axis_tlast <= is_end;
		do @(posedge clk); while (!s_axis_tready);
		predict_hull(p, is_end);
	endtask

	task automatic send_set(int n, int span);
		for (int i = 0; i < n; i++)
			send_point($signed(16'($urandom_range(2*span) - span)),
				$signed(16'($urandom_range(2*span) - span)), i == n-1);
	endtask

	task automatic test_extremes();
		send_point(-32768, -32768, 0);
		send_point(32767, 32767, 0);
		send_point(-32768, 32767, 0);
		send_point(32767, -32768, 1);
		send_point(0, 0, 1);
	endtask

	task automatic test_duplicates();
		send_point(5, -7, 0);
		send_point(5, -7, 1);
		send_point(1, 1, 0);
		send_point(1, 1, 0);
		send_point(1, 1, 1);
		// three collinear points and one off their line
		send_point(0, 0, 0);
		send_point(2, 2, 0);
		send_point(4, 4, 0);
		send_point(-3, 0, 1);
	endtask

	task automatic test_overflow();
		for (int i = 0; i < MAX_PTS + 3; i++)
			send_point($signed(16'($urandom)), $signed(16'($urandom)), i == MAX_PTS + 2);
	endtask

	task automatic test_random(int items);
		int n;
		while (items > 0) begin
			case ($urandom_range(3))
				0: n = $urandom_range(3, 12);
				1: n = $urandom_range(1, 3);
				default: n = $urandom_range(4, 20);
			endcase
			if (n > items) n = items;
			send_set(n, $urandom_range(1) ? 32767 : 4);
			items -= n;
		end
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 0;
		while (hull_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		errors = 0;
		n_pts = 0;
		dropped = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tlast = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_extremes();
		test_duplicates();
		test_overflow();
		test_random(30);
		send_idle_pct = 80;
		test_random(30);
		send_idle_pct = 0;
		recv_stall_pct = 80;
		test_random(30);
		send_idle_pct = 16;
		recv_stall_pct = 16;
		test_random(30);
		wait_drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
